FILE: design/bpp_pkg.sv
`default_nettype none
package bpp_pkg;

  localparam int FRAC        = 16;
  localparam int DIV_BPS     = 2;
  localparam int DIV_STAGES  = 32 / DIV_BPS;
  localparam int DIV_LAT     = DIV_STAGES + 2;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [63:0] wide_t;
  typedef fx_t   [2:0] vec3_t;
  typedef wide_t [5:0] prod6_t;
  typedef wide_t [2:0] wide3_t;

  localparam wide_t ONE_W  = 64'sd1 <<< FRAC;
  localparam wide_t HALF_W = 64'sd1 <<< (FRAC - 1);
  localparam wide_t MAX_W  = 64'sd2147483647;
  localparam wide_t MIN_W  = -64'sd2147483648;
  localparam fx_t   ONE_FX = fx_t'(ONE_W);
  localparam logic [31:0] SF_NUM = 32'(64'd2 << FRAC);

  typedef enum logic [2:0] {
    REG_FIELD_BX  = 3'd0,
    REG_FIELD_BY  = 3'd1,
    REG_FIELD_BZ  = 3'd2,
    REG_MAG_EN    = 3'd3,
    REG_TIME_STEP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] id;
    vec3_t       pos;
    vec3_t       vel;
    vec3_t       kick;
    vec3_t       vm;
    vec3_t       t;
    vec3_t       vp;
    vec3_t       s;
    vec3_t       vpl;
    fx_t         qmh;
    fx_t         den;
    prod6_t      prod;
    wide3_t      sq;
    logic        ov;
  } pl_t;

  // rounded fixed-point product, floor shift
  function automatic wide_t mul_raw(fx_t a, fx_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return (p + HALF_W) >>> FRAC;
  endfunction

  function automatic fx_t sat_w(wide_t x);
    if (x > MAX_W) return fx_t'(MAX_W);
    else if (x < MIN_W) return fx_t'(MIN_W);
    else return fx_t'(x);
  endfunction

  function automatic logic ov_w(wide_t x);
    return (x > MAX_W) || (x < MIN_W);
  endfunction

  function automatic wide_t add_ff(fx_t a, fx_t b);
    return wide_t'(a) + wide_t'(b);
  endfunction

  function automatic wide_t add_fw(fx_t a, wide_t b);
    return wide_t'(a) + b;
  endfunction

  function automatic wide_t sub_ww(wide_t a, wide_t b);
    return a - b;
  endfunction

  function automatic logic [31:0] abs_fx(fx_t a);
    logic [31:0] u;
    u = a;
    return a[31] ? (~u + 32'd1) : u;
  endfunction

  // pairs for a x b: component i = prod[2i] - prod[2i+1]
  function automatic prod6_t cross_prod(vec3_t a, vec3_t b);
    prod6_t p;
    p[0] = mul_raw(a[1], b[2]);
    p[1] = mul_raw(a[2], b[1]);
    p[2] = mul_raw(a[2], b[0]);
    p[3] = mul_raw(a[0], b[2]);
    p[4] = mul_raw(a[0], b[1]);
    p[5] = mul_raw(a[1], b[0]);
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: design/boris_particle_push.sv
// Boris push, one ion per transaction.
// Path from input acceptance to out_valid: two radix-4 divider pipelines
// in sequence plus nine multiply/add stages.
// Throughput: one transaction per cycle; the whole pipe stalls while a result waits.
// Synchronous active-low reset clears all valid bits and sets the field to
// zero, magnetic rotation off and time step to 1.0.
`default_nettype none
module boris_particle_push (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_ion_id,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  input  wire logic signed [31:0] in_force_x,
  input  wire logic signed [31:0] in_force_y,
  input  wire logic signed [31:0] in_force_z,
  input  wire logic [30:0]        in_ion_mass,
  input  wire logic signed [31:0] in_ion_charge,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_ion_id_out,
  output logic signed [31:0]      out_new_pos_x,
  output logic signed [31:0]      out_new_pos_y,
  output logic signed [31:0]      out_new_pos_z,
  output logic signed [31:0]      out_new_vel_x,
  output logic signed [31:0]      out_new_vel_y,
  output logic signed [31:0]      out_new_vel_z,
  output logic                    out_overflow,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  localparam int DL = bpp_pkg::DIV_LAT;

  bpp_pkg::fx_t field_bx_r, field_by_r, field_bz_r;
  logic         mag_en_r;
  logic [30:0]  dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_bx_r <= '0;
      field_by_r <= '0;
      field_bz_r <= '0;
      mag_en_r   <= 1'b0;
      dt_r       <= 31'(bpp_pkg::ONE_W);
    end else if (cfg_we) begin
      unique case (bpp_pkg::reg_idx_t'(cfg_index))
        bpp_pkg::REG_FIELD_BX:  field_bx_r <= cfg_wdata;
        bpp_pkg::REG_FIELD_BY:  field_by_r <= cfg_wdata;
        bpp_pkg::REG_FIELD_BZ:  field_bz_r <= cfg_wdata;
        bpp_pkg::REG_MAG_EN:    mag_en_r   <= cfg_wdata[0];
        bpp_pkg::REG_TIME_STEP: dt_r       <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  bpp_pkg::fx_t   hdt, dt_fx;
  bpp_pkg::vec3_t bfield;
  assign hdt    = bpp_pkg::fx_t'(({1'b0, dt_r} + 32'd1) >> 1);
  assign dt_fx  = bpp_pkg::fx_t'({1'b0, dt_r});
  assign bfield = {field_bz_r, field_by_r, field_bx_r};

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // first dividers: q/m and F/m
  logic [31:0]  mass_dvs;
  bpp_pkg::fx_t qm_q, acc_q [3];
  logic         qm_ov, acc_ov [3];
  bpp_pkg::fx_t frc [3];
  assign mass_dvs = (in_ion_mass == 31'd0) ? 32'd1 : {1'b0, in_ion_mass};
  assign frc[0] = in_force_x;
  assign frc[1] = in_force_y;
  assign frc[2] = in_force_z;

  bpp_div u_div_qm (
    .clk(clk), .en(en), .num_mag(bpp_pkg::abs_fx(in_ion_charge)),
    .num_neg(in_ion_charge[31]), .dvs(mass_dvs), .quo(qm_q), .quo_ov(qm_ov)
  );

  for (genvar i = 0; i < 3; i++) begin : g_acc
    bpp_div u_div_acc (
      .clk(clk), .en(en), .num_mag(bpp_pkg::abs_fx(frc[i])),
      .num_neg(frc[i][31]), .dvs(mass_dvs), .quo(acc_q[i]), .quo_ov(acc_ov[i])
    );
  end

  bpp_pkg::pl_t a_nxt;
  bpp_pkg::pl_t a_r [DL];
  logic         a_v_r [DL];

  always_comb begin
    a_nxt     = '0;
    a_nxt.id  = in_ion_id;
    a_nxt.pos = {in_pos_z, in_pos_y, in_pos_x};
    a_nxt.vel = {in_vel_z, in_vel_y, in_vel_x};
  end

  bpp_pkg::pl_t p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  bpp_pkg::pl_t p1_r, p2_r, p3_r, p4_r;
  logic         p1_v_r, p2_v_r, p3_v_r, p4_v_r;

  // half kick, q/m * dt/2
  always_comb begin
    bpp_pkg::wide_t w;
    logic           ov;
    p1_nxt = a_r[DL-1];
    ov = qm_ov | acc_ov[0] | acc_ov[1] | acc_ov[2];
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::mul_raw(acc_q[i], hdt);
      p1_nxt.kick[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
    end
    w = bpp_pkg::mul_raw(qm_q, hdt);
    p1_nxt.qmh = bpp_pkg::sat_w(w);
    ov = ov | (mag_en_r & bpp_pkg::ov_w(w));
    p1_nxt.ov = ov;
  end

  // v-, t
  always_comb begin
    bpp_pkg::wide_t w;
    logic           ov;
    p2_nxt = p1_r;
    ov = p1_r.ov;
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::add_ff(p1_r.vel[i], p1_r.kick[i]);
      p2_nxt.vm[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
      if (mag_en_r) begin
        w = bpp_pkg::mul_raw(bfield[i], p1_r.qmh);
        p2_nxt.t[i] = bpp_pkg::sat_w(w);
        ov = ov | bpp_pkg::ov_w(w);
      end else begin
        p2_nxt.t[i] = '0;
      end
    end
    p2_nxt.ov = ov;
  end

  always_comb begin
    p3_nxt = p2_r;
    for (int i = 0; i < 3; i++) begin
      p3_nxt.sq[i] = bpp_pkg::mul_raw(p2_r.t[i], p2_r.t[i]);
    end
    p3_nxt.prod = bpp_pkg::cross_prod(p2_r.vm, p2_r.t);
  end

  // |t|^2, 1 + |t|^2, v'
  always_comb begin
    bpp_pkg::wide_t w;
    bpp_pkg::fx_t   c;
    logic           ov;
    p4_nxt = p3_r;
    ov = p3_r.ov;
    w = p3_r.sq[0] + p3_r.sq[1] + p3_r.sq[2];
    c = bpp_pkg::sat_w(w);
    ov = ov | bpp_pkg::ov_w(w);
    w = bpp_pkg::add_ff(bpp_pkg::ONE_FX, c);
    p4_nxt.den = bpp_pkg::sat_w(w);
    ov = ov | bpp_pkg::ov_w(w);
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::sub_ww(p3_r.prod[2*i], p3_r.prod[2*i+1]);
      c = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
      w = bpp_pkg::add_ff(p3_r.vm[i], c);
      p4_nxt.vp[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
    end
    p4_nxt.ov = ov;
  end

  // s factor 2 / (1 + |t|^2)
  bpp_pkg::fx_t sf_q;
  logic         sf_ov;

  bpp_div u_div_sf (
    .clk(clk), .en(en), .num_mag(bpp_pkg::SF_NUM), .num_neg(1'b0),
    .dvs(32'(p4_r.den)), .quo(sf_q), .quo_ov(sf_ov)
  );

  bpp_pkg::pl_t q_r   [DL];
  logic         q_v_r [DL];

  bpp_pkg::pl_t r1_nxt, r2_nxt, r3_nxt, r4_nxt;
  bpp_pkg::pl_t r1_r, r2_r, r3_r, r4_r;
  logic         r1_v_r, r2_v_r, r3_v_r, r4_v_r;

  always_comb begin
    bpp_pkg::wide_t w;
    logic           ov;
    r1_nxt = q_r[DL-1];
    ov = q_r[DL-1].ov | sf_ov;
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::mul_raw(q_r[DL-1].t[i], sf_q);
      r1_nxt.s[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
    end
    r1_nxt.ov = ov;
  end

  always_comb begin
    r2_nxt = r1_r;
    r2_nxt.prod = bpp_pkg::cross_prod(r1_r.vp, r1_r.s);
  end

  // v+
  always_comb begin
    bpp_pkg::wide_t w;
    bpp_pkg::fx_t   c;
    logic           ov;
    r3_nxt = r2_r;
    ov = r2_r.ov;
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::sub_ww(r2_r.prod[2*i], r2_r.prod[2*i+1]);
      c = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
      w = bpp_pkg::add_ff(r2_r.vm[i], c);
      r3_nxt.vpl[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
    end
    r3_nxt.ov = ov;
  end

  // v+ * dt, new velocity (held in vel)
  always_comb begin
    bpp_pkg::wide_t w;
    logic           ov;
    r4_nxt = r3_r;
    ov = r3_r.ov;
    for (int i = 0; i < 3; i++) begin
      r4_nxt.prod[i] = bpp_pkg::mul_raw(r3_r.vpl[i], dt_fx);
      w = bpp_pkg::add_ff(r3_r.vpl[i], r3_r.kick[i]);
      r4_nxt.vel[i] = bpp_pkg::sat_w(w);
      ov = ov | bpp_pkg::ov_w(w);
    end
    r4_nxt.ov = ov;
  end

  logic [15:0]    out_id_r;
  bpp_pkg::vec3_t out_pos_r, out_pos_nxt, out_vel_r;
  logic           out_ov_r, out_ov_nxt;

  always_comb begin
    bpp_pkg::wide_t w;
    out_ov_nxt = r4_r.ov;
    for (int i = 0; i < 3; i++) begin
      w = bpp_pkg::add_fw(r4_r.pos[i], r4_r.prod[i]);
      out_pos_nxt[i] = bpp_pkg::sat_w(w);
      out_ov_nxt = out_ov_nxt | bpp_pkg::ov_w(w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= a_nxt;
      for (int k = 1; k < DL; k++) begin
        a_r[k] <= a_r[k-1];
      end
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      q_r[0] <= p4_r;
      for (int k = 1; k < DL; k++) begin
        q_r[k] <= q_r[k-1];
      end
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
      r4_r <= r4_nxt;
      out_id_r  <= r4_r.id;
      out_pos_r <= out_pos_nxt;
      out_vel_r <= r4_r.vel;
      out_ov_r  <= out_ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DL; k++) begin
        a_v_r[k] <= 1'b0;
        q_v_r[k] <= 1'b0;
      end
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      r1_v_r      <= 1'b0;
      r2_v_r      <= 1'b0;
      r3_v_r      <= 1'b0;
      r4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r[0] <= in_valid;
      for (int k = 1; k < DL; k++) begin
        a_v_r[k] <= a_v_r[k-1];
      end
      p1_v_r <= a_v_r[DL-1];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      q_v_r[0] <= p4_v_r;
      for (int k = 1; k < DL; k++) begin
        q_v_r[k] <= q_v_r[k-1];
      end
      r1_v_r      <= q_v_r[DL-1];
      r2_v_r      <= r1_v_r;
      r3_v_r      <= r2_v_r;
      r4_v_r      <= r3_v_r;
      out_valid_r <= r4_v_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ion_id_out = out_id_r;
  assign out_new_pos_x  = out_pos_r[0];
  assign out_new_pos_y  = out_pos_r[1];
  assign out_new_pos_z  = out_pos_r[2];
  assign out_new_vel_x  = out_vel_r[0];
  assign out_new_vel_y  = out_vel_r[1];
  assign out_new_vel_z  = out_vel_r[2];
  assign out_overflow   = out_ov_r;

endmodule
`default_nettype wire

FILE: design/bpp_div.sv
`default_nettype none
module bpp_div (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [31:0]   num_mag,
  input  wire logic          num_neg,
  input  wire logic [31:0]   dvs,
  output bpp_pkg::fx_t       quo,
  output logic               quo_ov
);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [31:0] dvs;
    logic        neg;
    logic        big;
  } div_st_t;

  div_st_t st_r   [bpp_pkg::DIV_STAGES+1];
  div_st_t st_nxt [bpp_pkg::DIV_STAGES+1];
  bpp_pkg::fx_t quo_r, quo_nxt;
  logic         ov_r, ov_nxt;

  always_comb begin
    div_st_t     s;
    logic [32:0] r2;
    st_nxt[0].rem = 32'(num_mag >> bpp_pkg::FRAC);
    st_nxt[0].lo  = num_mag << bpp_pkg::FRAC;
    st_nxt[0].q   = '0;
    st_nxt[0].dvs = dvs;
    st_nxt[0].neg = num_neg;
    st_nxt[0].big = (32'(num_mag >> bpp_pkg::FRAC) >= dvs);
    for (int k = 0; k < bpp_pkg::DIV_STAGES; k++) begin
      s = st_r[k];
      for (int j = 0; j < bpp_pkg::DIV_BPS; j++) begin
        r2   = {s.rem, s.lo[31]};
        s.lo = {s.lo[30:0], 1'b0};
        if (r2 >= {1'b0, s.dvs}) begin
          s.rem = 32'(r2 - {1'b0, s.dvs});
          s.q   = {s.q[30:0], 1'b1};
        end else begin
          s.rem = r2[31:0];
          s.q   = {s.q[30:0], 1'b0};
        end
      end
      st_nxt[k+1] = s;
    end
  end

  always_comb begin
    div_st_t f;
    f = st_r[bpp_pkg::DIV_STAGES];
    if (!f.neg) begin
      ov_nxt  = f.big | f.q[31];
      quo_nxt = ov_nxt ? bpp_pkg::fx_t'(bpp_pkg::MAX_W) : bpp_pkg::fx_t'(f.q);
    end else begin
      ov_nxt  = f.big | (f.q > 32'h8000_0000);
      quo_nxt = ov_nxt ? bpp_pkg::fx_t'(bpp_pkg::MIN_W) : bpp_pkg::fx_t'(~f.q + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= bpp_pkg::DIV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      quo_r <= quo_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign quo    = quo_r;
  assign quo_ov = ov_r;

endmodule
`default_nettype wire

FILE: verif/boris_particle_push_checker.sv
module boris_particle_push_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       in_ion_id,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  input  logic [30:0]       in_ion_mass,
  input  logic signed [31:0] in_ion_charge,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_ion_id_out,
  input  logic signed [31:0] out_new_pos_x,
  input  logic signed [31:0] out_new_pos_y,
  input  logic signed [31:0] out_new_pos_z,
  input  logic signed [31:0] out_new_vel_x,
  input  logic signed [31:0] out_new_vel_y,
  input  logic signed [31:0] out_new_vel_z,
  input  logic              out_overflow,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [15:0]      id;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic             ov;
  } push_res_t;

  push_res_t pushed_q[$];
  longint signed bfield [3];
  bit mag_on;
  longint signed dt;

  function automatic longint signed clip(longint signed x, ref bit ov);
    if (x > 64'sd2147483647) begin
      ov = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      ov = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint signed fmul(longint signed a, longint signed b);
    return (a * b + (64'sd1 <<< 15)) >>> 16;
  endfunction

  function automatic longint signed fdiv(longint signed n, longint signed d, ref bit ov);
    return clip((n * 65536) / d, ov);
  endfunction

  function automatic void rotate(longint signed base[3], longint signed a[3],
                                 longint signed b[3], ref longint signed r[3], ref bit ov);
    longint signed c [3];
    c[0] = clip(fmul(a[1], b[2]) - fmul(a[2], b[1]), ov);
    c[1] = clip(fmul(a[2], b[0]) - fmul(a[0], b[2]), ov);
    c[2] = clip(fmul(a[0], b[1]) - fmul(a[1], b[0]), ov);
    for (int i = 0; i < 3; i++) r[i] = clip(base[i] + c[i], ov);
  endfunction

  function automatic push_res_t boris_push(logic [15:0] id, longint signed pos[3],
                                           longint signed vel[3], longint signed frc[3],
                                           longint signed mass, longint signed q);
    push_res_t r;
    bit ov;
    longint signed kick[3], vm[3], tv[3], sv[3], vp[3], vpl[3], np[3], nv[3];
    longint signed qm, hdt, qmh, tsq, den, sf;
    ov = 0;
    if (mass == 0) mass = 1;
    qm = fdiv(q, mass, ov);
    hdt = clip(fmul(dt, 32768), ov);
    for (int i = 0; i < 3; i++) begin
      kick[i] = clip(fmul(fdiv(frc[i], mass, ov), hdt), ov);
      vm[i] = clip(vel[i] + kick[i], ov);
    end
    if (mag_on) begin
      qmh = clip(fmul(qm, hdt), ov);
      for (int i = 0; i < 3; i++) tv[i] = clip(fmul(bfield[i], qmh), ov);
    end else begin
      for (int i = 0; i < 3; i++) tv[i] = 0;
    end
    tsq = clip(fmul(tv[0], tv[0]) + fmul(tv[1], tv[1]) + fmul(tv[2], tv[2]), ov);
    den = clip(65536 + tsq, ov);
    sf = fdiv(2 * 65536, den, ov);
    for (int i = 0; i < 3; i++) sv[i] = clip(fmul(tv[i], sf), ov);
    rotate(vm, vm, tv, vp, ov);
    rotate(vm, vp, sv, vpl, ov);
    for (int i = 0; i < 3; i++) begin
      np[i] = clip(pos[i] + fmul(vpl[i], dt), ov);
      nv[i] = clip(vpl[i] + kick[i], ov);
    end
    r.id = id;
    r.px = 32'(np[0]); r.py = 32'(np[1]); r.pz = 32'(np[2]);
    r.vx = 32'(nv[0]); r.vy = 32'(nv[1]); r.vz = 32'(nv[2]);
    r.ov = ov;
    return r;
  endfunction

  assign pending = pushed_q.size();

  always @(posedge clk) begin
    push_res_t e, a;
    longint signed p[3], v[3], f[3];
    if (!rst_n) begin
      bfield = '{0, 0, 0};
      mag_on = 0;
      dt = 65536;
      errors = 0;
      pushed_q.delete();
    end else begin
      if (cfg_we) begin
        case (bpp_pkg::reg_idx_t'(cfg_index))
          bpp_pkg::REG_FIELD_BX:  bfield[0] = longint'($signed(cfg_wdata));
          bpp_pkg::REG_FIELD_BY:  bfield[1] = longint'($signed(cfg_wdata));
          bpp_pkg::REG_FIELD_BZ:  bfield[2] = longint'($signed(cfg_wdata));
          bpp_pkg::REG_MAG_EN:    mag_on = cfg_wdata[0];
          bpp_pkg::REG_TIME_STEP: dt = longint'({1'b0, cfg_wdata[30:0]});
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        p = '{in_pos_x, in_pos_y, in_pos_z};
        v = '{in_vel_x, in_vel_y, in_vel_z};
        f = '{in_force_x, in_force_y, in_force_z};
        pushed_q.push_back(boris_push(in_ion_id, p, v, f,
          longint'({1'b0, in_ion_mass}), longint'(in_ion_charge)));
      end
      if (out_valid && out_ready) begin
        a = '{out_ion_id_out, out_new_pos_x, out_new_pos_y, out_new_pos_z,
              out_new_vel_x, out_new_vel_y, out_new_vel_z, out_overflow};
        if (pushed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction id=%0d", a.id);
        end else begin
          e = pushed_q.pop_front();
          if (a !== e) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp id=%0d p=%0d,%0d,%0d v=%0d,%0d,%0d ov=%0b",
                e.id, e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.ov);
              $display("         got id=%0d p=%0d,%0d,%0d v=%0d,%0d,%0d ov=%0b",
                a.id, a.px, a.py, a.pz, a.vx, a.vy, a.vz, a.ov);
            end
          end
        end
      end
    end
  end

endmodule

FILE: verif/boris_particle_push_tb.sv
module boris_particle_push_tb;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] in_ion_id = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [31:0] in_vel_x = 0, in_vel_y = 0, in_vel_z = 0;
  logic signed [31:0] in_force_x = 0, in_force_y = 0, in_force_z = 0;
  logic [30:0] in_ion_mass = 1;
  logic signed [31:0] in_ion_charge = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_ion_id_out;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic out_overflow;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  int errors, pending;
  bit hold_rx = 0;
  bit stall_mode = 0;

  always #5 clk = ~clk;

  boris_particle_push DUT (.*);
  boris_particle_push_checker chk (.*);

  function automatic logic [31:0] rnd_fx(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  task automatic send_ion(logic [15:0] id, logic [31:0] p[3], logic [31:0] v[3],
                          logic [31:0] f[3], logic [30:0] m, logic [31:0] q);
    in_valid <= 1;
    in_ion_id <= id;
    in_pos_x <= p[0]; in_pos_y <= p[1]; in_pos_z <= p[2];
    in_vel_x <= v[0]; in_vel_y <= v[1]; in_vel_z <= v[2];
    in_force_x <= f[0]; in_force_y <= f[1]; in_force_z <= f[2];
    in_ion_mass <= m;
    in_ion_charge <= q;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int mode);
    logic [31:0] p[3], v[3], f[3];
    logic [30:0] m;
    for (int i = 0; i < 3; i++) begin
      p[i] = rnd_fx(mode);
      v[i] = rnd_fx(mode);
      f[i] = rnd_fx(mode);
    end
    case ($urandom_range(0, 5))
      0: m = 31'($urandom());
      1: m = 31'($urandom_range(0, 3));
      2: m = 31'h7fff_ffff;
      default: m = 31'($urandom_range(32'h4000, 32'h0040_0000));
    endcase
    send_ion(16'($urandom()), p, v, f, m, rnd_fx(mode));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(bpp_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_field(bit en, logic [31:0] dtv, int mode);
    write_reg(bpp_pkg::REG_FIELD_BX, rnd_fx(mode));
    write_reg(bpp_pkg::REG_FIELD_BY, rnd_fx(mode));
    write_reg(bpp_pkg::REG_FIELD_BZ, rnd_fx(mode));
    write_reg(bpp_pkg::REG_MAG_EN, {31'($urandom_range(0, 32'h7fff_ffff)), en});
    write_reg(bpp_pkg::REG_TIME_STEP, dtv);
    cfg_we <= 0;
  endtask

  always @(posedge clk) begin
    if (hold_rx) out_ready <= 0;
    else if (stall_mode) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] p[3], v[3], f[3];
    logic [31:0] steps[6];
    steps = '{32'h0001_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000,
              32'h0000_4000, 32'h8000_4000};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset configuration, directed extremes
    p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0};
    v = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
    f = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    send_ion(16'hffff, p, v, f, 31'h0, 32'h7fff_ffff);
    send_ion(16'h0000, p, v, f, 31'h7fff_ffff, 32'h8000_0000);
    p = '{32'h0, 32'h0, 32'h0};
    send_ion(16'h1, p, p, p, 31'h1_0000, 32'h0);
    drain();
    write_reg(bpp_pkg::REG_FIELD_BX, 32'h0001_0000);
    write_reg(bpp_pkg::REG_FIELD_BY, 32'h8000_0000);
    write_reg(bpp_pkg::REG_FIELD_BZ, 32'h7fff_ffff);
    write_reg(bpp_pkg::REG_MAG_EN, 32'hffff_ffff);
    write_reg(bpp_pkg::REG_TIME_STEP, 32'hffff_ffff);
    cfg_we <= 0;
    for (int i = 0; i < 8; i++) send_random(i % 4);
    drain();
    set_field(1, 32'h0, 1);
    for (int i = 0; i < 6; i++) send_random(i % 4);
    drain();

    // receiver held off while sender keeps pushing
    set_field(1, 32'h0001_0000, 3);
    fork
      begin
        hold_rx = 1;
        repeat (200) @(posedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 80; i++) send_random(1);
    join
    drain();

    stall_mode = 1;
    for (int ph = 0; ph < 12; ph++) begin
      set_field(1'($urandom_range(0, 1)), steps[ph % 6], $urandom_range(0, 3));
      stall_mode = ph[0];
      for (int n = 0; n < 70; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          send_random($urandom_range(0, 9) < 5 ? 1 : $urandom_range(0, 3));
          n++;
        end
        if ($urandom_range(0, 2) == 0) begin
          in_valid <= 0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/bpp_pkg.sv
design/bpp_div.sv
design/boris_particle_push.sv
verif/boris_particle_push_checker.sv
verif/boris_particle_push_tb.sv
